FILE: hdl/lrc_pkg.sv
// Package for the LRU resource cache: sizes, status codes and the entry record type.
// No dependencies; every module of the block imports it.
package lrc_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = 5;
  localparam int unsigned BytesW     = 36;

  typedef enum logic [2:0] {
    ST_REJECT   = 3'd0,
    ST_INSERT   = 3'd1,
    ST_REPLACE  = 3'd2,
    ST_EVICT    = 3'd3,
    ST_HIT      = 3'd4,
    ST_MISS     = 3'd5,
    ST_ERASED   = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    MODE_PUT      = 2'd0,
    MODE_FIND     = 2'd1,
    MODE_FIND_GEN = 2'd2,
    MODE_ERASE    = 2'd3
  } mode_e;

  // One cache record as kept in the entry memory.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] res;
    logic [31:0] size;
    logic [63:0] gen;
    logic [63:0] stamp;
  } entry_t;

  // Write request from the controller to the entry memory.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } mem_wr_t;

endpackage

FILE: hdl/lru_resource_cache_core.sv
// Top level of the LRU resource cache: handshakes, scan sequencer, counters.
// Depends on lrc_pkg and lrc_entry_ram.
//
// From acceptance to result the sequencer walks the slot memory one read a
// cycle through its single registered read port, picking the first key match,
// the first free slot and the oldest stamp, then performs at most one
// write-back. Valid bits, the entry count and the byte total live in
// flip-flops, so no clearing pass runs after reset. The next item is accepted
// in the cycle after the result is taken, so the block takes no new item
// before the last result has been taken, including any stall on the result
// side; capacity writes are accepted whenever the block is idle.
module lru_resource_cache_core
  import lrc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   mode_i,
  input  logic [63:0]  lookup_key_i,
  input  logic         key_valid_i,
  input  logic [63:0]  resource_id_i,
  input  logic [31:0]  entry_bytes_i,
  input  logic [63:0]  generation_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [2:0]   status_o,
  output logic [63:0]  out_key_o,
  output logic [63:0]  out_resource_id_o,
  output logic [31:0]  out_bytes_o,
  output logic [63:0]  out_generation_o,
  output logic [4:0]   entry_count_o,
  output logic [63:0]  hit_total_o,
  output logic [63:0]  miss_total_o,
  output logic [63:0]  eviction_total_o,
  output logic [35:0]  total_bytes_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  localparam logic [IdxW:0] LastIdx = (IdxW+1)'(MaxEntries - 1);

  state_e state_q, state_d;

  // Captured item.
  logic [1:0]  mode_q;
  logic [63:0] key_q, res_q, gen_q;
  logic [31:0] bytes_q;
  logic        kv_q;

  logic [4:0]  cap_q;
  logic [MaxEntries-1:0] valid_q;
  logic [IdxW:0] count_q;
  logic [BytesW:0] sum_q;
  logic [63:0] clock_q, hits_q, misses_q, evicts_q;

  // Scan bookkeeping.
  logic [IdxW:0]   ridx_q;     // next slot to read
  logic [IdxW:0]   cidx_q;     // slot whose data arrives this cycle
  logic            cval_q;     // data for cidx_q is on the read port
  logic            match_q, free_q, vict_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q, vict_idx_q;
  entry_t          match_e_q, vict_e_q;

  // Result register.
  logic [2:0]  st_q;
  entry_t      rep_q;
  logic        rep_en_q;

  mem_wr_t         wr;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  assign raddr = ridx_q[IdxW-1:0];

  lrc_entry_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic in_fire, out_fire, scan_end;
  logic [IdxW:0] cap_eff;
  logic [IdxW-1:0] cur;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign scan_end    = cval_q && (cidx_q == LastIdx);
  assign cur         = cidx_q[IdxW-1:0];
  assign cap_eff     = (cap_q > 5'(MaxEntries)) ? (IdxW+1)'(MaxEntries)
                                                : (IdxW+1)'(cap_q);

  // Decision after the scan, taken in S_DONE.
  logic put_ok, find_hit;
  assign put_ok   = kv_q && (res_q != '0) && (bytes_q != '0) && (gen_q != '0)
                    && (cap_q != '0);
  assign find_hit = kv_q && match_q &&
                    !((mode_q == MODE_FIND_GEN) &&
                      ((gen_q == '0) || (match_e_q.gen != gen_q)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_DONE;
      S_DONE:  state_d = S_OUT;
      S_OUT:   if (out_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Write-back decided from the scan results.
  logic [2:0] st_d;
  logic       rep_en_d;
  entry_t     rep_d;
  always_comb begin
    wr       = '0;
    st_d     = ST_REJECT;
    rep_en_d = 1'b0;
    rep_d    = match_e_q;
    if (state_q == S_DONE) begin
      case (mode_e'(mode_q))
        MODE_PUT: begin
          if (put_ok) begin
            if (match_q) begin
              if (gen_q >= match_e_q.gen) begin
                st_d     = ST_REPLACE;
                rep_en_d = 1'b1;
                wr.we    = 1'b1;
                wr.addr  = match_idx_q;
                wr.data  = '{key: key_q, res: res_q, size: bytes_q, gen: gen_q,
                             stamp: clock_q + 64'd1};
              end
            end else if (count_q < cap_eff) begin
              if (free_q) begin
                st_d    = ST_INSERT;
                wr.we   = 1'b1;
                wr.addr = free_idx_q;
                wr.data = '{key: key_q, res: res_q, size: bytes_q, gen: gen_q,
                            stamp: clock_q + 64'd1};
              end
            end else if (vict_q) begin
              st_d     = ST_EVICT;
              rep_en_d = 1'b1;
              rep_d    = vict_e_q;
              wr.we    = 1'b1;
              wr.addr  = vict_idx_q;
              wr.data  = '{key: key_q, res: res_q, size: bytes_q, gen: gen_q,
                           stamp: clock_q + 64'd1};
            end
          end
        end
        MODE_FIND, MODE_FIND_GEN: begin
          if (find_hit) begin
            st_d       = ST_HIT;
            rep_en_d   = 1'b1;
            wr.we      = 1'b1;
            wr.addr    = match_idx_q;
            wr.data    = match_e_q;
            wr.data.stamp = clock_q + 64'd1;
          end else begin
            st_d = ST_MISS;
          end
        end
        MODE_ERASE: begin
          if (kv_q && match_q) begin
            st_d     = ST_ERASED;
            rep_en_d = 1'b1;
          end else begin
            st_d = ST_NOTFOUND;
          end
        end
        default: st_d = ST_REJECT;
      endcase
    end
  end

  // Control state, scan and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= 5'd16;
      valid_q  <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      clock_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
      ridx_q   <= '0;
      cidx_q   <= '0;
      cval_q   <= 1'b0;
      match_q  <= 1'b0;
      free_q   <= 1'b0;
      vict_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (in_fire) begin
        ridx_q  <= '0;
        cval_q  <= 1'b0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
        vict_q  <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        // Issue one read a cycle; the data arrives in the cycle after.
        cval_q <= (ridx_q <= LastIdx);
        cidx_q <= ridx_q;
        if (ridx_q <= LastIdx) begin
          ridx_q <= ridx_q + 1'b1;
        end
        if (cval_q) begin
          if (valid_q[cur]) begin
            if (!match_q && (rdata.key == key_q)) begin
              match_q <= 1'b1;
            end
            if (!vict_q || (rdata.stamp < vict_e_q.stamp)) begin
              vict_q <= 1'b1;
            end
          end else if (!free_q) begin
            free_q <= 1'b1;
          end
        end
      end
      if (state_q == S_DONE) begin
        if ((mode_q == MODE_PUT) && put_ok) begin
          clock_q <= clock_q + 64'd1;
        end
        case (status_e'(st_d))
          ST_REPLACE: begin
            sum_q <= sum_q - (BytesW+1)'(match_e_q.size) + (BytesW+1)'(bytes_q);
          end
          ST_INSERT: begin
            valid_q[free_idx_q] <= 1'b1;
            count_q <= count_q + 1'b1;
            sum_q   <= sum_q + (BytesW+1)'(bytes_q);
          end
          ST_EVICT: begin
            evicts_q <= evicts_q + 64'd1;
            sum_q <= sum_q - (BytesW+1)'(vict_e_q.size) + (BytesW+1)'(bytes_q);
          end
          ST_HIT: begin
            clock_q <= clock_q + 64'd1;
            hits_q  <= hits_q + 64'd1;
          end
          ST_MISS: misses_q <= misses_q + 64'd1;
          ST_ERASED: begin
            valid_q[match_idx_q] <= 1'b0;
            count_q <= count_q - 1'b1;
            sum_q   <= sum_q - (BytesW+1)'(match_e_q.size);
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: captured item, scan picks and the result record.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_i;
      key_q   <= lookup_key_i;
      kv_q    <= key_valid_i;
      res_q   <= resource_id_i;
      bytes_q <= entry_bytes_i;
      gen_q   <= generation_i;
    end
    if ((state_q == S_SCAN) && cval_q) begin
      if (valid_q[cur]) begin
        if (!match_q && (rdata.key == key_q)) begin
          match_idx_q <= cur;
          match_e_q   <= rdata;
        end
        if (!vict_q || (rdata.stamp < vict_e_q.stamp)) begin
          vict_idx_q <= cur;
          vict_e_q   <= rdata;
        end
      end else if (!free_q) begin
        free_idx_q <= cur;
      end
    end
    if (state_q == S_DONE) begin
      st_q     <= st_d;
      rep_en_q <= rep_en_d;
      rep_q    <= rep_d;
    end
  end

  assign out_valid_o       = (state_q == S_OUT);
  assign status_o          = st_q;
  assign out_key_o         = rep_en_q ? rep_q.key  : '0;
  assign out_resource_id_o = rep_en_q ? rep_q.res  : '0;
  assign out_bytes_o       = rep_en_q ? rep_q.size : '0;
  assign out_generation_o  = rep_en_q ? rep_q.gen  : '0;
  assign entry_count_o     = CntW'(count_q);
  assign hit_total_o       = hits_q;
  assign miss_total_o      = misses_q;
  assign eviction_total_o  = evicts_q;
  assign total_bytes_o     = sum_q[BytesW] ? {BytesW{1'b1}} : sum_q[BytesW-1:0];

`ifndef NO_ASSERTIONS
  // The entry count always equals the number of set valid bits.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == (IdxW+1)'($countones(valid_q)))
    else $error("entry count out of step with valid bits");

  // Memory is written only in the decision cycle.
  a_wr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == S_DONE))
    else $error("entry write outside decision cycle");

  // A result is offered in the cycle after the decision.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_o)
    else $error("result not presented after decision");

  // Insert only fills a slot that was free.
  a_ins_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (st_d == ST_INSERT)) |-> !valid_q[free_idx_q])
    else $error("insert into occupied slot");
`endif

endmodule

FILE: hdl/lrc_entry_ram.sv
// Entry memory of the LRU resource cache: one record per slot, one write port,
// one read port with a registered read. Depends on lrc_pkg.
module lrc_entry_ram
  import lrc_pkg::*;
(
  input  logic            clk_i,
  input  mem_wr_t         wr_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [MaxEntries];

  // Write and registered read share the clock; the controller writes only after
  // its scan, so it never uses read data from a slot in the cycle it writes it.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: tb/lru_resource_cache_core_test.sv
// Self-checking testbench for lru_resource_cache_core: random and directed cache items,
// predicted by a local LRU cache model and checked field by field. Depends on lrc_pkg.
`timescale 1ns / 100ps

module lru_resource_cache_core_test;
  import lrc_pkg::*;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] key;
    logic        kv;
    logic [63:0] res;
    logic [31:0] bytes;
    logic [63:0] gen;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] key;
    logic [63:0] res;
    logic [31:0] bytes;
    logic [63:0] gen;
    logic [4:0]  count;
    logic [63:0] hits;
    logic [63:0] misses;
    logic [63:0] evicts;
    logic [35:0] total;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [4:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [63:0] lookup_key_i = '0;
  logic key_valid_i = 1'b0;
  logic [63:0] resource_id_i = '0;
  logic [31:0] entry_bytes_i = '0;
  logic [63:0] generation_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [63:0] out_key_o, out_resource_id_o, out_generation_o;
  logic [31:0] out_bytes_o;
  logic [4:0] entry_count_o;
  logic [63:0] hit_total_o, miss_total_o, eviction_total_o;
  logic [35:0] total_bytes_o;

  lru_resource_cache_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the cache state.
  logic [4:0]  cap_m;
  logic [63:0] m_key [MaxEntries];
  logic [63:0] m_res [MaxEntries];
  logic [31:0] m_size [MaxEntries];
  logic [63:0] m_gen [MaxEntries];
  logic [63:0] m_stamp [MaxEntries];
  logic        m_vld [MaxEntries];
  logic [63:0] use_clk, hit_cnt, miss_cnt, evict_cnt;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      errors = 0;
  bit      idle_free = 1'b0;
  bit      cfg_req = 1'b0;
  logic [4:0] cfg_value;
  longint  cycles = 0;
  int      in_gap = 0, out_gap = 0;
  logic [63:0] keys_pool [8];

  function automatic int lookup_slot(logic [63:0] k);
    for (int i = 0; i < MaxEntries; i++)
      if (m_vld[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  // Apply one item to the local cache and return the answer it should give.
  function automatic answer_t cache_step(op_t op);
    answer_t a;
    int slot, cnt, cap;
    logic [63:0] stamp;
    logic [36:0] sum;
    a = '0;
    a.status = ST_REJECT;
    cnt = 0;
    for (int i = 0; i < MaxEntries; i++) if (m_vld[i]) cnt++;
    cap = (cap_m > MaxEntries) ? MaxEntries : cap_m;
    case (op.mode)
      MODE_PUT: begin
        if (op.kv && op.res != 0 && op.bytes != 0 && op.gen != 0 && cap != 0) begin
          use_clk++;
          stamp = use_clk;
          slot = lookup_slot(op.key);
          if (slot >= 0) begin
            if (op.gen >= m_gen[slot]) begin
              a.key = m_key[slot]; a.res = m_res[slot];
              a.bytes = m_size[slot]; a.gen = m_gen[slot];
              m_res[slot] = op.res; m_size[slot] = op.bytes;
              m_gen[slot] = op.gen; m_stamp[slot] = stamp;
              a.status = ST_REPLACE;
            end
          end else if (cnt < cap) begin
            slot = -1;
            for (int i = MaxEntries - 1; i >= 0; i--) if (!m_vld[i]) slot = i;
            if (slot >= 0) begin
              m_key[slot] = op.key; m_res[slot] = op.res; m_size[slot] = op.bytes;
              m_gen[slot] = op.gen; m_stamp[slot] = stamp; m_vld[slot] = 1'b1;
              a.status = ST_INSERT;
            end
          end else begin
            slot = -1;
            for (int i = 0; i < MaxEntries; i++)
              if (m_vld[i] && (slot < 0 || m_stamp[i] < m_stamp[slot])) slot = i;
            if (slot >= 0) begin
              a.key = m_key[slot]; a.res = m_res[slot];
              a.bytes = m_size[slot]; a.gen = m_gen[slot];
              m_key[slot] = op.key; m_res[slot] = op.res; m_size[slot] = op.bytes;
              m_gen[slot] = op.gen; m_stamp[slot] = stamp;
              evict_cnt++;
              a.status = ST_EVICT;
            end
          end
        end
      end
      MODE_FIND, MODE_FIND_GEN: begin
        slot = -1;
        if (op.kv && !(op.mode == MODE_FIND_GEN && op.gen == 0)) begin
          slot = lookup_slot(op.key);
          if (slot >= 0 && op.mode == MODE_FIND_GEN && m_gen[slot] != op.gen) slot = -1;
        end
        if (slot >= 0) begin
          use_clk++;
          m_stamp[slot] = use_clk;
          hit_cnt++;
          a.key = m_key[slot]; a.res = m_res[slot];
          a.bytes = m_size[slot]; a.gen = m_gen[slot];
          a.status = ST_HIT;
        end else begin
          miss_cnt++;
          a.status = ST_MISS;
        end
      end
      default: begin
        slot = op.kv ? lookup_slot(op.key) : -1;
        if (slot >= 0) begin
          a.key = m_key[slot]; a.res = m_res[slot];
          a.bytes = m_size[slot]; a.gen = m_gen[slot];
          m_vld[slot] = 1'b0;
          a.status = ST_ERASED;
        end else a.status = ST_NOTFOUND;
      end
    endcase
    cnt = 0;
    sum = '0;
    for (int i = 0; i < MaxEntries; i++)
      if (m_vld[i]) begin
        cnt++;
        sum += m_size[i];
      end
    a.count = (cnt > 31) ? 5'd31 : cnt[4:0];
    a.hits = hit_cnt;
    a.misses = miss_cnt;
    a.evicts = evict_cnt;
    a.total = (sum > 37'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : sum[35:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Append one item to the tail of the pending queue.
  function automatic void enqueue_op(op_t o);
    pending_ops.insert(pending_ops.size(), o);
  endfunction

  // Sender: feeds pending items and capacity writes, with random bursts of idling.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
        cap_m = cfg_value;
        cfg_req = 1'b0;
      end else if (cfg_req && !cfg_valid_i) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i <= cfg_value;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i)
          expected_answers.insert(expected_answers.size(),
                                  cache_step(pending_ops.pop_front()));
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0 && !cfg_req) begin
          in_valid_i <= 1'b1;
          mode_i <= pending_ops[0].mode;
          lookup_key_i <= pending_ops[0].key;
          key_valid_i <= pending_ops[0].kv;
          resource_id_i <= pending_ops[0].res;
          entry_bytes_i <= pending_ops[0].bytes;
          generation_i <= pending_ops[0].gen;
          if (!idle_free && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 6);
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and every accepted answer is checked.
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          $display("unexpected answer at cycle %0d", cycles);
          errors++;
        end else begin
          w = expected_answers.pop_front();
          if (status_o != w.status) report_mismatch("status", status_o, w.status);
          if (out_key_o != w.key) report_mismatch("key", out_key_o, w.key);
          if (out_resource_id_o != w.res) report_mismatch("resource", out_resource_id_o, w.res);
          if (out_bytes_o != w.bytes) report_mismatch("bytes", out_bytes_o, w.bytes);
          if (out_generation_o != w.gen) report_mismatch("gen", out_generation_o, w.gen);
          if (entry_count_o != w.count) report_mismatch("count", entry_count_o, w.count);
          if (hit_total_o != w.hits) report_mismatch("hits", hit_total_o, w.hits);
          if (miss_total_o != w.misses) report_mismatch("misses", miss_total_o, w.misses);
          if (eviction_total_o != w.evicts)
            report_mismatch("evictions", eviction_total_o, w.evicts);
          if (total_bytes_o != w.total) report_mismatch("total", total_bytes_o, w.total);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!idle_free && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 6);
      end
    end
  end

  function automatic op_t make_op(mode_e m, logic [63:0] k, logic kv, logic [63:0] r,
                                  logic [31:0] b, logic [63:0] g);
    op_t o;
    o.mode = m; o.key = k; o.kv = kv; o.res = r; o.bytes = b; o.gen = g;
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly well-formed items on a small key pool, with some noise.
  function automatic op_t random_op();
    op_t o;
    int pick;
    o.mode = mode_e'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) o.mode = MODE_PUT;
    pick = $urandom_range(0, 19);
    o.key = (pick < 18) ? keys_pool[pick % 8] ^ (pick >= 8 ? 64'd0 + pick : 64'd0)
                        : rand64();
    o.kv = ($urandom_range(0, 15) != 0);
    o.res = ($urandom_range(0, 19) == 0) ? 64'd0 : rand64();
    case ($urandom_range(0, 9))
      0: o.bytes = 32'd0;
      1: o.bytes = 32'hFFFF_FFFF;
      default: o.bytes = $urandom();
    endcase
    case ($urandom_range(0, 9))
      0: o.gen = 64'd0;
      1: o.gen = 64'hFFFF_FFFF_FFFF_FFFF;
      2: o.gen = rand64();
      default: o.gen = $urandom_range(1, 4);
    endcase
    return o;
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] v);
    cfg_value = v;
    cfg_req = 1'b1;
    while (cfg_req) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Cycle limit: far above the slowest correct run.
  always @(posedge clk_i) begin
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [4:0] caps [6];
    caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd17};
    cap_m = 5'd16;
    use_clk = '0; hit_cnt = '0; miss_cnt = '0; evict_cnt = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      m_vld[i] = 1'b0; m_key[i] = '0; m_res[i] = '0;
      m_size[i] = '0; m_gen[i] = '0; m_stamp[i] = '0;
    end
    for (int i = 0; i < 8; i++) keys_pool[i] = rand64();
    keys_pool[0] = 64'd0;
    keys_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every mode, operand checks, older generation,
    // invalid key, and eviction once full.
    enqueue_op(make_op(MODE_FIND, 64'd0, 1'b1, 0, 0, 0));
    enqueue_op(make_op(MODE_PUT, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                       32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    enqueue_op(make_op(MODE_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1, 1, 1));
    enqueue_op(make_op(MODE_PUT, 64'd5, 1'b0, 1, 1, 1));
    enqueue_op(make_op(MODE_PUT, 64'd5, 1'b1, 0, 1, 1));
    enqueue_op(make_op(MODE_PUT, 64'd5, 1'b1, 1, 0, 1));
    enqueue_op(make_op(MODE_PUT, 64'd5, 1'b1, 1, 1, 0));
    enqueue_op(make_op(MODE_PUT, 64'd0, 1'b1, 7, 7, 3));
    enqueue_op(make_op(MODE_FIND_GEN, 64'd0, 1'b1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    enqueue_op(make_op(MODE_FIND_GEN, 64'd0, 1'b1, 0, 0, 0));
    enqueue_op(make_op(MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0));
    enqueue_op(make_op(MODE_ERASE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0));
    enqueue_op(make_op(MODE_ERASE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, 0, 0));
    enqueue_op(make_op(MODE_ERASE, 64'd77, 1'b1, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      enqueue_op(make_op(MODE_PUT, 64'd100 + i, 1'b1, 64'd1 + i, 32'hFFFF_FFFF, 64'd2));
    // The sender runs dry here and waits until every answer has come back.
    wait_drained();

    // Random phases across capacity settings; the last one runs without idling.
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      if (p == 5) idle_free = 1'b1;
      for (int n = 0; n < 310; n++) enqueue_op(random_op());
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
